/* rtl/sta_pkg.sv */
// Shared types and constants for the segment table allocator.
`timescale 1ns / 1ps
package sta_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned PosBits     = 4;
  localparam int unsigned CntBits     = 5;
  localparam int unsigned AddrBits    = 16;
  localparam int unsigned MaxMoves    = 15;
  localparam int unsigned QueueDepth  = 2;

  typedef logic [AddrBits-1:0] addr_t;

  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActRelease = 2'd1;
  localparam logic [1:0] ActCompact = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StBadPos   = 3'd3;
  localparam logic [2:0] StMoved    = 3'd4;

  localparam logic RegMemorySize = 1'b0;
  localparam logic RegFitPolicy  = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] request_size;
    logic [7:0]  owner;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_position;
    logic [15:0] old_start;
    logic [15:0] new_start;
    logic [15:0] length;
    logic [15:0] free_total;
    logic        last;
  } rsp_t;

  // Classified request passed from front to back.
  typedef enum logic [2:0] {
    OpAlloc, OpRelease, OpCompact, OpNoFit, OpIgnore
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] request_size;
    logic [7:0]  owner;
    logic [3:0]  position;
  } cmd_t;

endpackage

/* rtl/sta_front.sv */
// Front end: accept requests, screen trivial ones and queue them for the back end.
`timescale 1ns / 1ps
module sta_front
  import sta_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic push,
  output logic full,
  output cmd_t cmd_o,
  output logic cmd_valid_o,
  input  logic cmd_take_i
);

  cmd_t                cmd_mem_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QueueDepth):0]   cnt_q;
  cmd_t                cmd_in;
  logic                do_push, do_pop;

  always_comb begin
    cmd_in.request_size = req_i.request_size;
    cmd_in.owner        = req_i.owner;
    cmd_in.position     = req_i.position;
    unique case (req_i.action)
      ActAlloc: begin
        cmd_in.op = (req_i.request_size == '0 || req_i.owner == '0) ? OpNoFit : OpAlloc;
      end
      ActRelease: cmd_in.op = OpRelease;
      ActCompact: cmd_in.op = OpCompact;
      default:    cmd_in.op = OpIgnore;
    endcase
  end

  assign full        = (cnt_q == QueueDepth[$clog2(QueueDepth):0]);
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cnt_q != '0;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = cmd_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) cmd_mem_q[wr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QueueDepth){1'b0}}, do_push}
                     - {{$clog2(QueueDepth){1'b0}}, do_pop};
    end
  end

endmodule

/* rtl/sta_back.sv */
// Back end: sequencer that scans, edits and compacts the segment table.
`timescale 1ns / 1ps
module sta_back
  import sta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] memory_size_i,
  input  logic        fit_policy_i,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_take_o,
  output rsp_t        rsp_o,
  output logic        empty,
  input  logic        pop
);

  typedef enum logic [3:0] {
    SIdle, SScan, SAlloc, SShiftUp, SRelease, SShiftDn, SMerge,
    SCount, SCompact, SFree, STail, SOut
  } state_e;

  state_e        state_q;
  cmd_t          cmd_q;
  addr_t         start_q [MaxSegments];
  addr_t         size_q  [MaxSegments];
  logic [7:0]    owner_q [MaxSegments];
  logic [CntBits-1:0] count_q;
  logic [PosBits-1:0] idx_q, wr_q, pos_q;
  logic [CntBits-1:0] scan_q;
  logic          found_q, seen_q, rm_q;
  logic [PosBits-1:0] best_q;
  logic [16:0]   used_q, free_q;
  logic [3:0]    nmov_q;
  rsp_t          rsp_q;
  logic          rsp_v_q;
  logic [2:0]    fin_st_q;
  logic [PosBits-1:0] fin_pos_q;
  addr_t         fin_new_q, fin_len_q;

  logic          out_free;
  logic          rsp_load;
  logic [PosBits-1:0] si;
  logic [16:0]   tail;
  logic [16:0]   fs_add;

  assign rsp_o      = rsp_q;
  assign empty      = !rsp_v_q;
  assign out_free   = !rsp_v_q || pop;
  assign cmd_take_o = (state_q == SIdle) && cmd_valid_i;
  assign si         = scan_q[PosBits-1:0];
  assign tail       = ({1'b0, memory_size_i} > used_q) ? {1'b0, memory_size_i} - used_q : '0;
  assign fs_add     = free_q + {1'b0, size_q[si]};
  // A result register load happens on a move or on the final result.
  assign rsp_load   = out_free &&
                      ((state_q == SOut) ||
                       (state_q == SCompact && scan_q < count_q && owner_q[si] != '0 &&
                        seen_q && nmov_q < 4'(MaxMoves)));

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && cmd_valid_i) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (rsp_load) rsp_v_q <= 1'b1;
      else if (pop) rsp_v_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cmd_valid_i) begin
            scan_q  <= '0;
            found_q <= 1'b0;
            seen_q  <= 1'b0;
            used_q  <= '0;
            nmov_q  <= '0;
            wr_q    <= '0;
            rm_q    <= 1'b0;
            unique case (cmd_i.op)
              OpAlloc:   state_q <= SScan;
              OpRelease: state_q <= SRelease;
              OpCompact: state_q <= SCount;
              OpNoFit: begin
                fin_st_q <= StNoFit; fin_pos_q <= '0; fin_new_q <= '0; fin_len_q <= '0;
                free_q <= '0; state_q <= SFree;
              end
              default: begin
                fin_st_q <= StOk; fin_pos_q <= '0; fin_new_q <= '0; fin_len_q <= '0;
                free_q <= '0; state_q <= SFree;
              end
            endcase
          end
        end
        // Walk the table once for a fitting free segment.
        SScan: begin
          if (scan_q >= count_q) state_q <= SAlloc;
          else begin
            if (owner_q[si] == '0 && size_q[si] >= cmd_q.request_size) begin
              if (!found_q || (fit_policy_i && size_q[si] <= size_q[best_q])) best_q <= si;
              found_q <= 1'b1;
              if (!fit_policy_i) state_q <= SAlloc;
            end
            scan_q <= scan_q + 1'b1;
          end
        end
        SAlloc: begin
          free_q <= '0;
          if (!found_q) begin
            fin_st_q <= StNoFit; fin_pos_q <= '0; fin_new_q <= '0; fin_len_q <= '0;
            scan_q <= '0;
            state_q <= SFree;
          end else if (size_q[best_q] == cmd_q.request_size) begin
            owner_q[best_q] <= cmd_q.owner;
            fin_st_q <= StOk; fin_pos_q <= best_q; fin_new_q <= start_q[best_q];
            fin_len_q <= cmd_q.request_size;
            scan_q <= '0;
            state_q <= SFree;
          end else if (count_q >= CntBits'(MaxSegments)) begin
            fin_st_q <= StFull; fin_pos_q <= '0; fin_new_q <= '0; fin_len_q <= '0;
            scan_q <= '0;
            state_q <= SFree;
          end else begin
            scan_q <= count_q;
            state_q <= SShiftUp;
          end
        end
        // Open a gap above the chosen entry, one entry a cycle, then split.
        SShiftUp: begin
          if (scan_q > {1'b0, best_q} + 5'd1) begin
            start_q[si] <= start_q[si - 1'b1];
            size_q[si]  <= size_q[si - 1'b1];
            owner_q[si] <= owner_q[si - 1'b1];
            scan_q <= scan_q - 1'b1;
          end else begin
            start_q[best_q + 1'b1] <= start_q[best_q] + cmd_q.request_size;
            size_q[best_q + 1'b1]  <= size_q[best_q] - cmd_q.request_size;
            owner_q[best_q + 1'b1] <= '0;
            size_q[best_q]  <= cmd_q.request_size;
            owner_q[best_q] <= cmd_q.owner;
            count_q <= count_q + 1'b1;
            fin_st_q <= StOk; fin_pos_q <= best_q; fin_new_q <= start_q[best_q];
            fin_len_q <= cmd_q.request_size;
            scan_q <= '0; free_q <= '0;
            state_q <= SFree;
          end
        end
        SRelease: begin
          pos_q <= cmd_q.position;
          if ({1'b0, cmd_q.position} >= count_q || owner_q[cmd_q.position] == '0) begin
            fin_st_q <= StBadPos; fin_pos_q <= '0; fin_new_q <= '0; fin_len_q <= '0;
            scan_q <= '0; free_q <= '0; state_q <= SFree;
          end else begin
            owner_q[cmd_q.position] <= '0;
            if ({1'b0, cmd_q.position} + 5'd1 < count_q &&
                owner_q[cmd_q.position + 1'b1] == '0) begin
              size_q[cmd_q.position] <= size_q[cmd_q.position] + size_q[cmd_q.position + 1'b1];
              scan_q <= {1'b0, cmd_q.position} + 5'd1;
              rm_q <= 1'b0;
              state_q <= SShiftDn;
            end else state_q <= SMerge;
          end
        end
        // Close the gap at scan_q, one entry a cycle.
        SShiftDn: begin
          if (scan_q + 5'd1 < count_q) begin
            start_q[si] <= start_q[si + 1'b1];
            size_q[si]  <= size_q[si + 1'b1];
            owner_q[si] <= owner_q[si + 1'b1];
            scan_q <= scan_q + 1'b1;
          end else begin
            count_q <= count_q - 1'b1;
            if (rm_q) begin
              fin_st_q <= StOk; fin_pos_q <= pos_q; fin_new_q <= start_q[pos_q];
              fin_len_q <= size_q[pos_q];
              scan_q <= '0; free_q <= '0; state_q <= SFree;
            end else state_q <= SMerge;
          end
        end
        SMerge: begin
          if (pos_q != '0 && owner_q[pos_q - 1'b1] == '0) begin
            size_q[pos_q - 1'b1] <= size_q[pos_q - 1'b1] + size_q[pos_q];
            scan_q <= {1'b0, pos_q};
            pos_q <= pos_q - 1'b1;
            rm_q <= 1'b1;
            state_q <= SShiftDn;
          end else begin
            fin_st_q <= StOk; fin_pos_q <= pos_q; fin_new_q <= start_q[pos_q];
            fin_len_q <= size_q[pos_q];
            scan_q <= '0; free_q <= '0; state_q <= SFree;
          end
        end
        // Sum used sizes first so every move request carries the final free total.
        SCount: begin
          if (scan_q >= count_q) begin
            free_q <= (tail != '0 && !(count_q == CntBits'(MaxSegments) && !seen_q)) ?
                      tail : '0;
            used_q <= '0;
            seen_q <= 1'b0;
            scan_q <= '0;
            state_q <= SCompact;
          end else begin
            if (owner_q[si] == '0) seen_q <= 1'b1;
            else used_q <= used_q + {1'b0, size_q[si]};
            scan_q <= scan_q + 1'b1;
          end
        end
        // Slide used entries down; emit a move request when one is shifted, for at most the first 15 moves.
        SCompact: begin
          if (scan_q >= count_q) begin
            count_q <= {1'b0, wr_q} + (used_q != '0 || wr_q != '0 ? 5'd0 : 5'd0);
            state_q <= STail;
          end else if (owner_q[si] == '0) begin
            seen_q <= 1'b1;
            scan_q <= scan_q + 1'b1;
          end else if (!(seen_q && nmov_q < 4'(MaxMoves)) || out_free) begin
            if (seen_q && nmov_q < 4'(MaxMoves)) begin
              rsp_q <= '{status: StMoved, entry_position: wr_q, old_start: start_q[si],
                         new_start: used_q[15:0], length: size_q[si],
                         free_total: free_q[15:0], last: 1'b0};
              nmov_q <= nmov_q + 1'b1;
            end
            start_q[wr_q] <= used_q[15:0];
            size_q[wr_q]  <= size_q[si];
            owner_q[wr_q] <= owner_q[si];
            used_q <= used_q + {1'b0, size_q[si]};
            wr_q <= wr_q + 1'b1;
            scan_q <= scan_q + 1'b1;
            if (scan_q == CntBits'(MaxSegments - 1)) begin
              // Last slot holds a used entry; wr_q wraps only if every entry was used.
              count_q <= CntBits'(MaxSegments);
            end
          end
        end
        STail: begin
          // count_q holds the compacted count; a wrapped write index means a full table.
          if (rm_q == 1'b0 && wr_q == '0 && used_q != '0 && count_q == '0)
            count_q <= CntBits'(MaxSegments);
          if (tail != '0 && count_q < CntBits'(MaxSegments) &&
              !(wr_q == '0 && count_q == '0 && used_q != '0)) begin
            start_q[count_q[PosBits-1:0]] <= used_q[15:0];
            size_q[count_q[PosBits-1:0]]  <= tail[15:0];
            owner_q[count_q[PosBits-1:0]] <= '0;
            fin_pos_q <= count_q[PosBits-1:0];
            fin_len_q <= tail[15:0];
            count_q <= count_q + 1'b1;
          end else begin
            fin_pos_q <= '0;
            fin_len_q <= '0;
          end
          fin_st_q <= StOk;
          fin_new_q <= used_q[15:0];
          scan_q <= '0; free_q <= '0;
          state_q <= SFree;
        end
        // Sum free sizes, saturating at the field width.
        SFree: begin
          if (scan_q >= count_q) state_q <= SOut;
          else begin
            if (owner_q[si] == '0) free_q <= fs_add[16] ? 17'h0FFFF : fs_add;
            scan_q <= scan_q + 1'b1;
          end
        end
        SOut: begin
          if (out_free) begin
            rsp_q <= '{status: fin_st_q, entry_position: fin_pos_q, old_start: '0,
                       new_start: fin_new_q, length: fin_len_q,
                       free_total: free_q[15:0], last: 1'b1};
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

/* rtl/segment_table_allocator_core.sv */
// Top level of the segment table allocator.
`timescale 1ns / 1ps
// Segment table allocator over a 16-entry address-ordered table. Requests
// enter a two-deep queue and are executed one at a time by a sequencer that
// visits one table entry per cycle. Allocate scans the table, shifts entries
// to split the chosen segment when it is larger and sums the free total; release
// closes up to two gaps and sums the free total; compact runs a sizing pass, the
// slide and the sum. A result waits in the output register until it is popped.
// Compact stalls while a move result waits to be popped. Every result, moves
// included, carries the free total after the request. Configure only while idle.
module segment_table_allocator_core
  import sta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        push,
  output logic        full,
  output rsp_t        rsp_o,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] memory_size_q;
  logic        fit_policy_q;
  cmd_t        cmd;
  logic        cmd_valid, cmd_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_size_q <= 16'hFFFF;
      fit_policy_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMemorySize: memory_size_q <= cfg_data_i;
        RegFitPolicy:  fit_policy_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sta_front u_front (
    .clk_i, .rst_ni, .req_i, .push, .full,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take)
  );

  sta_back u_back (
    .clk_i, .rst_ni,
    .memory_size_i(memory_size_q), .fit_policy_i(fit_policy_q),
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .rsp_o, .empty, .pop
  );

endmodule
